### rtl/mhfp_pkg.sv
// ----------------------------------------------------------------------------
// Mail header field parser - shared definitions
// Action codes, parse and line state codes, and the command word that the
// front end hands to the result sequencer through the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhfp_pkg;

  // Token action reported to the consumer
  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_CLEAR  = 3'd1,
    ACT_NAME   = 3'd2,
    ACT_STORE  = 3'd3,
    ACT_DROP   = 3'd4,
    ACT_FINISH = 3'd5
  } action_e;

  // Parse position
  typedef enum logic [2:0] {
    PS_NAME_START = 3'd0,
    PS_NAME       = 3'd1,
    PS_COLON      = 3'd2,
    PS_VALUE      = 3'd3,
    PS_FOLD       = 3'd4,
    PS_SKIP       = 3'd5
  } parse_state_e;

  // CR/LF position
  typedef enum logic [1:0] {
    LS_START = 2'd0,
    LS_MID   = 2'd1,
    LS_CR    = 2'd2
  } line_state_e;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  // Result slots in emission order
  localparam int unsigned NumSlots  = 6;
  localparam int unsigned SlotPre   = 0;  // clear / commit / folding space
  localparam int unsigned SlotCr    = 1;  // held-back carriage return
  localparam int unsigned SlotMain  = 2;  // name take or byte append
  localparam int unsigned SlotClose = 3;  // closing clear
  localparam int unsigned SlotCmt   = 4;  // closing commit
  localparam int unsigned SlotFin   = 5;  // finish

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef logic [NumSlots-1:0] slot_mask_t;

  // One input byte's worth of results
  typedef struct packed {
    slot_mask_t   mask;
    action_e      pre_act;
    logic [7:0]   pre_byte;
    action_e      main_act;
    logic [7:0]   main_byte;
    action_e      cmt_act;
    parse_state_e fin_state;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/mhfp_front.sv
// ----------------------------------------------------------------------------
// Mail header field parser - front end
// Accepts header bytes, tracks parse/line state and turns each byte into a
// command word listing the results it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module mhfp_front
  import mhfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic is_last_i,
  input  wire logic q_full_i,
  output logic      push_o,
  output cmd_t      push_cmd_o
);

  parse_state_e ps_q, ps_d;
  line_state_e  ls_q, ls_d;
  logic         tn_q, tn_d;
  logic         nn_q, nn_d;
  logic         stopped_q, stopped_d;
  logic         accept;
  cmd_t         cmd;

  function automatic action_e commit_act(input logic tn, input logic nn);
    return (tn && nn) ? ACT_STORE : ACT_DROP;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    logic ls_start;
    logic ls_cr;
    logic done;
    ls_start  = (ls_q == LS_START);
    ls_cr     = (ls_q == LS_CR);
    done      = 1'b0;
    ps_d      = ps_q;
    ls_d      = ls_q;
    tn_d      = tn_q;
    nn_d      = nn_q;
    stopped_d = stopped_q;
    cmd           = '0;
    cmd.pre_act   = ACT_APPEND;
    cmd.main_act  = ACT_APPEND;
    cmd.cmt_act   = ACT_DROP;
    cmd.fin_state = PS_NAME_START;

    if (stopped_q) begin
      if (is_last_i) begin
        ps_d      = PS_NAME_START;
        ls_d      = LS_START;
        tn_d      = 1'b0;
        nn_d      = 1'b0;
        stopped_d = 1'b0;
      end
    end else begin
      case (data_byte_i)
        ChColon: begin
          if (ls_cr) begin
            cmd.mask[SlotCr] = 1'b1;
            tn_d = 1'b1;
          end
          if (ps_q == PS_NAME_START || ps_q == PS_NAME) begin
            nn_d = tn_q | ls_cr;
            tn_d = 1'b0;
            cmd.mask[SlotMain] = 1'b1;
            cmd.main_act = ACT_NAME;
            ps_d = PS_COLON;
          end else begin
            cmd.mask[SlotMain] = 1'b1;
            cmd.main_byte = data_byte_i;
            tn_d = 1'b1;
          end
          ls_d = LS_MID;
        end
        ChLf: begin
          if (ls_start) done = 1'b1;
          else          ls_d = LS_START;
        end
        ChCr: begin
          if (ls_cr) begin
            cmd.mask[SlotCr] = 1'b1;
            tn_d = 1'b1;
          end else begin
            ls_d = LS_CR;
          end
        end
        ChSpace, ChTab: begin
          if (ls_start) begin
            ps_d = (ps_q == PS_VALUE) ? PS_FOLD : PS_SKIP;
          end else begin
            if (ls_cr) begin
              cmd.mask[SlotCr] = 1'b1;
              tn_d = 1'b1;
            end
            if (ps_q == PS_NAME || ps_q == PS_VALUE) begin
              cmd.mask[SlotMain] = 1'b1;
              cmd.main_byte = data_byte_i;
              tn_d = 1'b1;
            end
          end
          ls_d = LS_MID;
        end
        default: begin
          case (ps_q)
            PS_NAME_START: begin
              cmd.mask[SlotPre] = 1'b1;
              cmd.pre_act = ACT_CLEAR;
              tn_d = 1'b0;
              ps_d = PS_NAME;
            end
            PS_COLON: begin
              cmd.mask[SlotPre] = 1'b1;
              tn_d = 1'b0;
              if (!ls_start) begin
                cmd.pre_act = ACT_CLEAR;
                ps_d = PS_VALUE;
              end else begin
                cmd.pre_act = commit_act(tn_q, nn_q);
                ps_d = PS_NAME;
              end
            end
            PS_VALUE: begin
              if (ls_start) begin
                cmd.mask[SlotPre] = 1'b1;
                cmd.pre_act = commit_act(tn_q, nn_q);
                tn_d = 1'b0;
                ps_d = PS_NAME;
              end
            end
            PS_FOLD: begin
              cmd.mask[SlotPre] = 1'b1;
              cmd.pre_byte = ChSpace;
              ps_d = PS_VALUE;
            end
            default: ;
          endcase
          if (ls_cr) cmd.mask[SlotCr] = 1'b1;
          cmd.mask[SlotMain] = 1'b1;
          cmd.main_byte = data_byte_i;
          tn_d = 1'b1;
          ls_d = LS_MID;
        end
      endcase

      if (done || is_last_i) begin
        if (ps_d == PS_COLON) begin
          cmd.mask[SlotClose] = 1'b1;
          tn_d = 1'b0;
          ps_d = PS_VALUE;
        end
        if (ps_d == PS_VALUE) begin
          cmd.mask[SlotCmt] = 1'b1;
          cmd.cmt_act = commit_act(tn_d, nn_d);
          tn_d = 1'b0;
        end
        cmd.mask[SlotFin] = 1'b1;
        cmd.fin_state = ps_d;
        if (is_last_i) begin
          ps_d = PS_NAME_START;
          ls_d = LS_START;
          tn_d = 1'b0;
          nn_d = 1'b0;
        end else begin
          stopped_d = 1'b1;
        end
      end
    end
  end

  assign push_o     = accept && (cmd.mask != '0);
  assign push_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q      <= PS_NAME_START;
      ls_q      <= LS_START;
      tn_q      <= 1'b0;
      nn_q      <= 1'b0;
      stopped_q <= 1'b0;
    end else if (accept) begin
      ps_q      <= ps_d;
      ls_q      <= ls_d;
      tn_q      <= tn_d;
      nn_q      <= nn_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

`default_nettype wire

### rtl/mhfp_queue.sv
// ----------------------------------------------------------------------------
// Mail header field parser - command queue
// Small register FIFO of command words between front end and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mhfp_queue
  import mhfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  output logic      empty_o,
  output cmd_t      head_o,
  input  wire logic pop_i
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/mhfp_back.sv
// ----------------------------------------------------------------------------
// Mail header field parser - result sequencer
// Walks the queue head's slot mask; one result per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mhfp_back
  import mhfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_empty_i,
  input  wire cmd_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output logic [2:0] action_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] final_state_o,
  output logic      run_end_o
);

  slot_mask_t sent_q, sent_d;
  slot_mask_t rem;
  slot_mask_t pick;
  action_e    act;
  logic       xfer;

  assign rem  = head_i.mask & ~sent_q;
  assign pick = rem & (~rem + 1'b1);  // lowest pending slot

  assign out_valid_o = !q_empty_i;
  assign xfer        = out_valid_o && !out_stall_i;
  assign run_end_o   = (rem == pick);
  assign pop_o       = xfer && run_end_o;

  always_comb begin
    act           = ACT_APPEND;
    out_byte_o    = '0;
    final_state_o = '0;
    if (pick[SlotPre]) begin
      act        = head_i.pre_act;
      out_byte_o = head_i.pre_byte;
    end else if (pick[SlotCr]) begin
      out_byte_o = ChCr;
    end else if (pick[SlotMain]) begin
      act        = head_i.main_act;
      out_byte_o = head_i.main_byte;
    end else if (pick[SlotClose]) begin
      act = ACT_CLEAR;
    end else if (pick[SlotCmt]) begin
      act = head_i.cmt_act;
    end else if (pick[SlotFin]) begin
      act           = ACT_FINISH;
      final_state_o = head_i.fin_state;
    end
  end

  assign action_o = act;

  always_comb begin
    sent_d = sent_q;
    if (xfer) sent_d = run_end_o ? '0 : (sent_q | pick);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sent_q <= '0;
    else         sent_q <= sent_d;
  end

  a_valid_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rem != '0))
    else $error("queued command has no pending result");

  a_finish_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && act == ACT_FINISH) |-> run_end_o)
    else $error("finish is not the last result of its byte");

  a_sent_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((sent_q & ~head_i.mask) == '0))
    else $error("issued slot outside head mask");

  a_sent_clear_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (sent_q == '0))
    else $error("slot record not cleared after pop");

endmodule

`default_nettype wire

### rtl/mail_header_field_parser_core.sv
// ----------------------------------------------------------------------------
// Mail header field parser - top level
// Byte-wise header unfolding: front end classifies bytes into commands, a
// two-entry queue decouples it from the sequencer that issues token actions.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | sink      | in_valid_i/in_stall_o | data_byte_i, is_last_i
//  out     | source    | out_valid_o/out_stall_i| action_o, out_byte_o,
//          |           |                      | final_state_o, run_end_o
//
//  Rates: one input byte per cycle is accepted while the command queue has
//  room; each result is one transfer on the output port, so a byte with k
//  results (k = 0..5) takes k transfers from the sequencer. Sustained rate
//  is one result per cycle, set by the output port while out_stall_i is low.
//  Reset: rst_ni is asynchronous, active low; parse state, queue pointers and
//  the sequencer's slot record are cleared.
//  Stalls: in_stall_o rises only when the queue is full; out_stall_i holds the
//  current result, the front end keeps running until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module mail_header_field_parser_core
  import mhfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       is_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      action_o,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      final_state_o,
  output logic            run_end_o
);

  // front end -> queue
  logic push;
  cmd_t push_cmd;
  logic q_full;
  // queue -> sequencer
  logic q_empty;
  cmd_t head;
  logic pop;

  // Front end: state tracking and per-byte command build
  mhfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .is_last_i   (is_last_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  // Decoupling queue; bytes with no results never enter it
  mhfp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Sequencer: one transfer per pending slot, in slot order
  mhfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .out_byte_o    (out_byte_o),
    .final_state_o (final_state_o),
    .run_end_o     (run_end_o)
  );

endmodule

`default_nettype wire
